@@ hdl/csmp_pkg.sv @@
`timescale 1ns / 1ps
package csmp_pkg;

  localparam int IDX_W      = 23;
  localparam int HALF_W     = IDX_W - 1;
  localparam int CNT_W      = 24;
  localparam int SPLIT_W    = 10;
  localparam int SEG_W      = 18;
  localparam int COORD_W    = 18;
  localparam int FRAC_BITS  = 16;
  localparam int MAX_SPLIT  = 1023;
  localparam int PROD_W     = HALF_W + 1 + SEG_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [COORD_W-1:0] ONE_FIX     = COORD_W'(2 ** FRAC_BITS);
  localparam logic [COORD_W-1:0] NEG_ONE_FIX = COORD_W'(0) - ONE_FIX;
  localparam logic [PROD_W-1:0]  TWO_FIX     = PROD_W'(2 ** (FRAC_BITS + 1));
  localparam logic [IDX_W-1:0]   VERTEX_CNT  = IDX_W'(8);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_X     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_Y     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_Z     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_X   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_Y   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_Z   = 3'd6;

  typedef enum logic [2:0] {
    RG_VERTEX,
    RG_EDGE_X,
    RG_EDGE_Y,
    RG_EDGE_Z,
    RG_FACE_Z,
    RG_FACE_Y,
    RG_FACE_X
  } region_t;

  typedef struct packed {
    region_t          region;
    logic [IDX_W-1:0] rem_idx;
  } entry_t;

  typedef struct packed {
    logic [SPLIT_W-1:0] x;
    logic [SPLIT_W-1:0] y;
    logic [SPLIT_W-1:0] z;
  } split_t;

  typedef struct packed {
    logic [SEG_W-1:0] x;
    logic [SEG_W-1:0] y;
    logic [SEG_W-1:0] z;
  } segment_t;

  function automatic logic [SPLIT_W-1:0] clamp_split(input logic [SPLIT_W-1:0] s);
    if (32'(s) > MAX_SPLIT) begin
      return SPLIT_W'(MAX_SPLIT);
    end
    return s;
  endfunction

endpackage

@@ hdl/csmp_front.sv @@
`timescale 1ns / 1ps
module csmp_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [csmp_pkg::IDX_W-1:0]        in_idx,
  input  logic                              cfg_write,
  input  logic [csmp_pkg::CNT_W-1:0]        point_count,
  input  csmp_pkg::split_t                  splits,
  output logic                              push,
  output csmp_pkg::entry_t                  push_data,
  input  logic                              queue_full
);

  localparam int PW = 2 * csmp_pkg::SPLIT_W;
  localparam int IW = csmp_pkg::IDX_W;

  // Region boundaries derived from the split counts, three register stages deep.
  logic [PW-1:0]                 prod_xy_r, prod_xz_r;
  logic [csmp_pkg::IDX_W-1:0]    b2_r, b3_r, b4_r, face_z_r, face_zy_r;
  logic [csmp_pkg::IDX_W-1:0]    b4_d_r, b2_d_r, b3_d_r, b5_r, b6_r;
  logic [1:0]                    settle_r;

  logic                          s1_vld_r, s2_vld_r;
  logic [csmp_pkg::IDX_W-1:0]    s1_idx_r, s2_idx_r;
  logic [5:0]                    s2_ge_r;
  logic [5:0]                    ge;
  logic                          keep;
  logic                          adv;
  csmp_pkg::region_t             region;
  logic [csmp_pkg::IDX_W-1:0]    base;

  always_ff @(posedge clk) begin
    prod_xy_r <= PW'(splits.x) * PW'(splits.y);
    prod_xz_r <= PW'(splits.x) * PW'(splits.z);
    b2_r      <= csmp_pkg::VERTEX_CNT + IW'({splits.x, 2'b00});
    b3_r      <= csmp_pkg::VERTEX_CNT + IW'({splits.x, 2'b00}) + IW'({splits.y, 2'b00});
    b4_r      <= csmp_pkg::VERTEX_CNT + IW'({splits.x, 2'b00}) + IW'({splits.y, 2'b00})
                 + IW'({splits.z, 2'b00});
    face_z_r  <= IW'({prod_xy_r, 1'b0});
    face_zy_r <= IW'({prod_xy_r, 1'b0}) + IW'({prod_xz_r, 1'b0});
    b2_d_r    <= b2_r;
    b3_d_r    <= b3_r;
    b4_d_r    <= b4_r;
    b5_r      <= b4_r + face_z_r;
    b6_r      <= b4_r + face_zy_r;
  end

  // New items wait until the boundaries reflect the latest register write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= 2'd3;
    end else if (cfg_write) begin
      settle_r <= 2'd3;
    end else if (settle_r != 2'd0) begin
      settle_r <= settle_r - 2'd1;
    end
  end

  assign push     = s2_vld_r && !queue_full;
  assign adv      = !s2_vld_r || !queue_full;
  assign in_ready = adv && (settle_r == 2'd0);

  assign keep  = (point_count >= csmp_pkg::CNT_W'(8)) &&
                 ({1'b0, s1_idx_r} < point_count);
  assign ge[0] = s1_idx_r >= csmp_pkg::VERTEX_CNT;
  assign ge[1] = s1_idx_r >= b2_d_r;
  assign ge[2] = s1_idx_r >= b3_d_r;
  assign ge[3] = s1_idx_r >= b4_d_r;
  assign ge[4] = s1_idx_r >= b5_r;
  assign ge[5] = s1_idx_r >= b6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_valid && in_ready;
      s2_vld_r <= s1_vld_r && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_idx_r <= in_idx;
      s2_idx_r <= s1_idx_r;
      s2_ge_r  <= ge;
    end
  end

  // Boundaries never decrease, so the compare flags form a thermometer code.
  always_comb begin
    if (s2_ge_r[5]) begin
      region = csmp_pkg::RG_FACE_X;
      base   = b6_r;
    end else if (s2_ge_r[4]) begin
      region = csmp_pkg::RG_FACE_Y;
      base   = b5_r;
    end else if (s2_ge_r[3]) begin
      region = csmp_pkg::RG_FACE_Z;
      base   = b4_d_r;
    end else if (s2_ge_r[2]) begin
      region = csmp_pkg::RG_EDGE_Z;
      base   = b3_d_r;
    end else if (s2_ge_r[1]) begin
      region = csmp_pkg::RG_EDGE_Y;
      base   = b2_d_r;
    end else if (s2_ge_r[0]) begin
      region = csmp_pkg::RG_EDGE_X;
      base   = csmp_pkg::VERTEX_CNT;
    end else begin
      region = csmp_pkg::RG_VERTEX;
      base   = '0;
    end
  end

  assign push_data.region  = region;
  assign push_data.rem_idx = s2_idx_r - base;

endmodule

@@ hdl/csmp_fifo.sv @@
`timescale 1ns / 1ps
module csmp_fifo #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  csmp_pkg::entry_t push_data,
  output logic             full,
  input  logic             pop,
  output csmp_pkg::entry_t pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  csmp_pkg::entry_t   mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

@@ hdl/csmp_back.sv @@
`timescale 1ns / 1ps
module csmp_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              queue_empty,
  input  csmp_pkg::entry_t                  queue_data,
  output logic                              pop,
  input  csmp_pkg::split_t                  splits,
  input  csmp_pkg::segment_t                segs,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [csmp_pkg::COORD_W-1:0]      out_x,
  output logic [csmp_pkg::COORD_W-1:0]      out_y,
  output logic [csmp_pkg::COORD_W-1:0]      out_z
);

  localparam int HW = csmp_pkg::HALF_W;
  localparam int SW = csmp_pkg::SPLIT_W;
  localparam int PW = csmp_pkg::PROD_W;

  typedef struct packed {
    csmp_pkg::region_t          region;
    logic [csmp_pkg::IDX_W-1:0] ri;
    logic [SW-1:0]              dvs;
    logic [SW-1:0]              rem;
    logic [HW-1:0]              dq;
  } dstage_t;

  typedef struct packed {
    logic          grid;
    logic          side;
    logic [HW-1:0] k;
  } axis_t;

  typedef struct packed {
    logic          grid;
    logic          side;
    logic [PW-1:0] prod;
  } prod_t;

  // One quotient bit per stage of restoring division.
  function automatic dstage_t div_step(input dstage_t s);
    logic [SW:0] t;
    logic        qb;
    dstage_t     o;
    o = s;
    t = {s.rem, s.dq[HW-1]};
    if (t >= {1'b0, s.dvs}) begin
      o.rem = SW'(t - {1'b0, s.dvs});
      qb    = 1'b1;
    end else begin
      o.rem = t[SW-1:0];
      qb    = 1'b0;
    end
    o.dq = {s.dq[HW-2:0], qb};
    return o;
  endfunction

  function automatic prod_t grid_mul(input axis_t a, input logic [csmp_pkg::SEG_W-1:0] seg);
    prod_t p;
    p.grid = a.grid;
    p.side = a.side;
    p.prod = PW'({1'b0, a.k} + (HW + 1)'(1)) * PW'(seg);
    return p;
  endfunction

  function automatic logic [csmp_pkg::COORD_W-1:0] finish(input prod_t p);
    if (!p.grid) begin
      return p.side ? csmp_pkg::NEG_ONE_FIX : csmp_pkg::ONE_FIX;
    end
    if (p.prod > csmp_pkg::TWO_FIX) begin
      return csmp_pkg::ONE_FIX;
    end
    return p.prod[csmp_pkg::COORD_W-1:0] - csmp_pkg::ONE_FIX;
  endfunction

  logic                          en;
  logic [HW:0]                   dvld_r;
  dstage_t                       dst_r [HW+1];
  dstage_t                       last;
  logic [HW-1:0]                 quo, rmd;
  logic [HW-1:0]                 quarter;
  axis_t                         ax, ay, az;
  axis_t                         ax_r, ay_r, az_r;
  prod_t                         px_r, py_r, pz_r;
  logic                          m0_vld_r, m1_vld_r, out_vld_r;
  logic [csmp_pkg::COORD_W-1:0]  out_x_r, out_y_r, out_z_r;

  // The whole back pipeline moves whenever the output register can take a result.
  assign en  = !out_vld_r || out_ready;
  assign pop = en && !queue_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvld_r    <= '0;
      m0_vld_r  <= 1'b0;
      m1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      dvld_r    <= {dvld_r[HW-1:0], pop};
      m0_vld_r  <= dvld_r[HW];
      m1_vld_r  <= m0_vld_r;
      out_vld_r <= m1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dst_r[0].region <= queue_data.region;
      dst_r[0].ri     <= queue_data.rem_idx;
      dst_r[0].dvs    <= (queue_data.region == csmp_pkg::RG_FACE_Z) ? splits.y : splits.z;
      dst_r[0].rem    <= '0;
      dst_r[0].dq     <= queue_data.rem_idx[csmp_pkg::IDX_W-1:1];
    end
  end

  for (genvar i = 1; i <= HW; i++) begin : g_div
    always_ff @(posedge clk) begin
      if (en) begin
        dst_r[i] <= div_step(dst_r[i-1]);
      end
    end
  end

  assign last    = dst_r[HW];
  // A zero divisor leaves the quotient at zero and the whole dividend as remainder.
  assign quo     = (last.dvs == '0) ? '0 : last.dq;
  assign rmd     = (last.dvs == '0) ? last.ri[csmp_pkg::IDX_W-1:1] : HW'(last.rem);
  assign quarter = HW'(last.ri[csmp_pkg::IDX_W-1:2]);

  always_comb begin
    ax = '{grid: 1'b0, side: last.ri[0], k: quo};
    ay = '{grid: 1'b0, side: last.ri[0], k: rmd};
    az = '{grid: 1'b0, side: last.ri[0], k: rmd};
    case (last.region)
      csmp_pkg::RG_VERTEX: begin
        ax.side = last.ri[2];
        ay.side = last.ri[1];
      end
      csmp_pkg::RG_EDGE_X: begin
        ax = '{grid: 1'b1, side: 1'b0, k: quarter};
        ay.side = last.ri[1];
      end
      csmp_pkg::RG_EDGE_Y: begin
        ax.side = last.ri[1];
        ay = '{grid: 1'b1, side: 1'b0, k: quarter};
      end
      csmp_pkg::RG_EDGE_Z: begin
        ax.side = last.ri[1];
        az = '{grid: 1'b1, side: 1'b0, k: quarter};
      end
      csmp_pkg::RG_FACE_Z: begin
        ax.grid = 1'b1;
        ay.grid = 1'b1;
      end
      csmp_pkg::RG_FACE_Y: begin
        ax.grid = 1'b1;
        az.grid = 1'b1;
      end
      default: begin
        ay = '{grid: 1'b1, side: 1'b0, k: quo};
        az.grid = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r    <= ax;
      ay_r    <= ay;
      az_r    <= az;
      px_r    <= grid_mul(ax_r, segs.x);
      py_r    <= grid_mul(ay_r, segs.y);
      pz_r    <= grid_mul(az_r, segs.z);
      out_x_r <= finish(px_r);
      out_y_r <= finish(py_r);
      out_z_r <= finish(pz_r);
    end
  end

  assign out_valid = out_vld_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_z     = out_z_r;

endmodule

@@ hdl/cube_surface_mesh_point_core.sv @@
`timescale 1ns / 1ps
// Surface mesh point generator for the cube [-1,1]^3.
// Software writes the point count, the three split counts and the three
// segment lengths (Q2.16) through the cfg channel while the block is idle;
// cfg_ready is always high. A write holds in_tready low while the region
// boundaries are recomputed.
// The in channel carries one point index per transfer. Indices at or past
// the point count, or any index while the count is below eight, give no
// result. Every other index gives one result on the out channel with the
// x, y and z coordinates, in input order.
// The front end classifies an index into its region and writes it into a
// small queue; the back end runs a 22-stage pipelined restoring divider,
// a multiply stage and a scaling stage. One index is taken per cycle while
// nothing stalls and no register write is settling.
// When the receiver holds out_tready low the back pipeline freezes, the
// queue fills and then in_tready falls. Reset clears the configuration
// registers to zero, empties the pipeline and the queue, and blocks input
// until the region boundaries are recomputed.
module cube_surface_mesh_point_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [csmp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [csmp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [23:0]                         in_tdata,   // point_index[22:0], zero
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [55:0]                         out_tdata   // coord_x, coord_y, coord_z, zero
);

  logic [csmp_pkg::CNT_W-1:0]   point_count_r;
  csmp_pkg::split_t             split_r;
  csmp_pkg::segment_t           seg_r;
  csmp_pkg::split_t             split_sat;
  logic                         cfg_write;

  logic                         push, pop, full, empty;
  csmp_pkg::entry_t             push_data, pop_data;
  logic [csmp_pkg::COORD_W-1:0] cx, cy, cz;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= '0;
      split_r       <= '0;
      seg_r         <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        csmp_pkg::CFG_POINT_COUNT: point_count_r <= cfg_data;
        csmp_pkg::CFG_SPLIT_X:     split_r.x <= cfg_data[csmp_pkg::SPLIT_W-1:0];
        csmp_pkg::CFG_SPLIT_Y:     split_r.y <= cfg_data[csmp_pkg::SPLIT_W-1:0];
        csmp_pkg::CFG_SPLIT_Z:     split_r.z <= cfg_data[csmp_pkg::SPLIT_W-1:0];
        csmp_pkg::CFG_SEGMENT_X:   seg_r.x <= cfg_data[csmp_pkg::SEG_W-1:0];
        csmp_pkg::CFG_SEGMENT_Y:   seg_r.y <= cfg_data[csmp_pkg::SEG_W-1:0];
        csmp_pkg::CFG_SEGMENT_Z:   seg_r.z <= cfg_data[csmp_pkg::SEG_W-1:0];
        default: ;
      endcase
    end
  end

  assign split_sat.x = csmp_pkg::clamp_split(split_r.x);
  assign split_sat.y = csmp_pkg::clamp_split(split_r.y);
  assign split_sat.z = csmp_pkg::clamp_split(split_r.z);

  csmp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_idx      (in_tdata[csmp_pkg::IDX_W-1:0]),
    .cfg_write   (cfg_write),
    .point_count (point_count_r),
    .splits      (split_sat),
    .push        (push),
    .push_data   (push_data),
    .queue_full  (full)
  );

  csmp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  csmp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .queue_empty (empty),
    .queue_data  (pop_data),
    .pop         (pop),
    .splits      (split_sat),
    .segs        (seg_r),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_x       (cx),
    .out_y       (cy),
    .out_z       (cz)
  );

  assign out_tdata = {2'b00, cz, cy, cx};

endmodule

@@ hdl/csmp_checker.sv @@
`timescale 1ns / 1ps
module csmp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);

  // A result held back by the receiver stays put until it is transferred.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result presented right after reset");

  // Region boundaries are being rebuilt after a register write.
  a_cfg_settle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> !in_tready ##1 !in_tready)
    else $error("input taken while boundaries settle");

  a_coord_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[55:54] == 2'b00
      && $signed(out_tdata[17:0]) <= 18'sd65536 && $signed(out_tdata[17:0]) >= -18'sd65536
      && $signed(out_tdata[35:18]) <= 18'sd65536 && $signed(out_tdata[35:18]) >= -18'sd65536
      && $signed(out_tdata[53:36]) <= 18'sd65536 && $signed(out_tdata[53:36]) >= -18'sd65536)
    else $error("coordinate outside the cube");

endmodule

bind cube_surface_mesh_point_core csmp_checker u_csmp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ sim/mesh_point_checker.sv @@
`timescale 1ns / 1ps
module mesh_point_checker
  import csmp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [23:0]           in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [55:0]           out_tdata,
  output int                    errors,
  output int                    pending
);

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } coord_t;

  logic [CNT_W-1:0] point_total;
  split_t           splits;
  segment_t         segs;
  coord_t           coords_due[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic logic [COORD_W-1:0] unit_side(input logic neg);
    return neg ? NEG_ONE_FIX : ONE_FIX;
  endfunction

  // Grid position k sits at -1 + (k+1)*seg, never beyond +1.
  function automatic logic [COORD_W-1:0] grid_point(input logic [63:0] k,
                                                    input logic [SEG_W-1:0] seg);
    logic [63:0] prod;
    prod = (k + 64'd1) * 64'(seg);
    if (prod > (64'd2 << FRAC_BITS)) begin
      prod = 64'd2 << FRAC_BITS;
    end
    return COORD_W'(prod - (64'd1 << FRAC_BITS));
  endfunction

  function automatic bit mesh_point_coords(input logic [IDX_W-1:0] idx, output coord_t c);
    logic [63:0] sx, sy, sz, rem, half, q, r;
    logic [63:0] span[6];
    int          rg;
    sx = (32'(splits.x) > MAX_SPLIT) ? 64'(MAX_SPLIT) : 64'(splits.x);
    sy = (32'(splits.y) > MAX_SPLIT) ? 64'(MAX_SPLIT) : 64'(splits.y);
    sz = (32'(splits.z) > MAX_SPLIT) ? 64'(MAX_SPLIT) : 64'(splits.z);
    c = '0;
    if (64'(point_total) < 64'(VERTEX_CNT) || 64'(idx) >= 64'(point_total)) begin
      return 0;
    end
    span[0] = 64'(VERTEX_CNT);
    span[1] = 4 * sx;
    span[2] = 4 * sy;
    span[3] = 4 * sz;
    span[4] = 2 * sx * sy;
    span[5] = 2 * sx * sz;
    rem = 64'(idx);
    rg = 0;
    // Anything left after the last counted region lands on the x faces.
    while (rg < 6 && rem >= span[rg]) begin
      rem = rem - span[rg];
      rg++;
    end
    half = rem >> 1;
    case (region_t'(rg))
      RG_VERTEX: begin
        c.x = unit_side(rem[2]);
        c.y = unit_side(rem[1]);
        c.z = unit_side(rem[0]);
      end
      RG_EDGE_X: begin
        c.x = grid_point(rem >> 2, segs.x);
        c.y = unit_side(rem[1]);
        c.z = unit_side(rem[0]);
      end
      RG_EDGE_Y: begin
        c.x = unit_side(rem[1]);
        c.y = grid_point(rem >> 2, segs.y);
        c.z = unit_side(rem[0]);
      end
      RG_EDGE_Z: begin
        c.x = unit_side(rem[1]);
        c.y = unit_side(rem[0]);
        c.z = grid_point(rem >> 2, segs.z);
      end
      RG_FACE_Z: begin
        q = (sy != 0) ? half / sy : 64'd0;
        r = half - q * sy;
        c.x = grid_point(q, segs.x);
        c.y = grid_point(r, segs.y);
        c.z = unit_side(rem[0]);
      end
      RG_FACE_Y: begin
        q = (sz != 0) ? half / sz : 64'd0;
        r = half - q * sz;
        c.x = grid_point(q, segs.x);
        c.y = unit_side(rem[0]);
        c.z = grid_point(r, segs.z);
      end
      default: begin
        q = (sz != 0) ? half / sz : 64'd0;
        r = half - q * sz;
        c.x = unit_side(rem[0]);
        c.y = grid_point(q, segs.y);
        c.z = grid_point(r, segs.z);
      end
    endcase
    return 1;
  endfunction

  task automatic report(input string msg);
    errors++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    coord_t got, want;
    if (!rst_n) begin
      point_total <= '0;
      splits      <= '0;
      segs        <= '0;
      coords_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.x = out_tdata[COORD_W-1:0];
        got.y = out_tdata[2*COORD_W-1:COORD_W];
        got.z = out_tdata[3*COORD_W-1:2*COORD_W];
        if (coords_due.size() == 0) begin
          report($sformatf("unexpected result x=%0d y=%0d z=%0d",
                           $signed(got.x), $signed(got.y), $signed(got.z)));
        end else begin
          want = coords_due.pop_front();
          if (got.x !== want.x) begin
            report($sformatf("coord_x %0d, expected %0d", $signed(got.x), $signed(want.x)));
          end
          if (got.y !== want.y) begin
            report($sformatf("coord_y %0d, expected %0d", $signed(got.y), $signed(want.y)));
          end
          if (got.z !== want.z) begin
            report($sformatf("coord_z %0d, expected %0d", $signed(got.z), $signed(want.z)));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (mesh_point_coords(in_tdata[IDX_W-1:0], want)) begin
          coords_due.push_back(want);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_POINT_COUNT: point_total <= cfg_data[CNT_W-1:0];
          CFG_SPLIT_X:     splits.x    <= cfg_data[SPLIT_W-1:0];
          CFG_SPLIT_Y:     splits.y    <= cfg_data[SPLIT_W-1:0];
          CFG_SPLIT_Z:     splits.z    <= cfg_data[SPLIT_W-1:0];
          CFG_SEGMENT_X:   segs.x      <= cfg_data[SEG_W-1:0];
          CFG_SEGMENT_Y:   segs.y      <= cfg_data[SEG_W-1:0];
          CFG_SEGMENT_Z:   segs.z      <= cfg_data[SEG_W-1:0];
          default: ;
        endcase
      end
    end
    pending <= coords_due.size();
  end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import csmp_pkg::*;

  localparam int PHASE_ITEMS = 240;
  localparam int DRAIN_CYCLES = 40;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [23:0]           in_tdata;    // point_index[22:0], zero
  logic                  out_tvalid;
  logic                  out_tready = 1'b1;
  logic [55:0]           out_tdata;   // coord_x, coord_y, coord_z, zero
  int                    errors;
  int                    pending;

  int                    send_idle_pct;
  int                    stall_pct;
  int                    valid_sent;

  // Stimulus-side copy of the mesh setup, used to aim indices at regions and to count indices with a result.
  logic [63:0]           pts, spx, spy, spz;

  cube_surface_mesh_point_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  mesh_point_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .errors     (errors),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic set_idling(input int mode);
    case (mode)
      1: begin send_idle_pct = 71; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 71; end
      3: begin send_idle_pct = 37; stall_pct = 37; end
      default: begin send_idle_pct = 0; stall_pct = 0; end
    endcase
  endtask

  // Registers change only when the block is empty, including indices with no result.
  task automatic wait_idle();
    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic load_mesh(input logic [63:0] pc, input logic [63:0] sx,
                           input logic [63:0] sy, input logic [63:0] sz,
                           input logic [63:0] gx, input logic [63:0] gy,
                           input logic [63:0] gz);
    in_tvalid <= 1'b0;
    wait_idle();
    pts = pc;
    spx = sx;
    spy = sy;
    spz = sz;
    cfg_write(CFG_POINT_COUNT, pc);
    cfg_write(CFG_SPLIT_X, sx);
    cfg_write(CFG_SPLIT_Y, sy);
    cfg_write(CFG_SPLIT_Z, sz);
    cfg_write(CFG_SEGMENT_X, gx);
    cfg_write(CFG_SEGMENT_Y, gy);
    cfg_write(CFG_SEGMENT_Z, gz);
    cfg_valid <= 1'b0;
  endtask

  // Count and spacings as software would derive them from the splits.
  task automatic load_cube(input logic [63:0] sx, input logic [63:0] sy,
                           input logic [63:0] sz);
    logic [63:0] pc;
    pc = 8 + 4 * (sx + sy + sz) + 2 * (sx * sy + sx * sz + sy * sz);
    load_mesh(pc, sx, sy, sz, 131072 / (sx + 1), 131072 / (sy + 1), 131072 / (sz + 1));
  endtask

  task automatic send_index(input logic [63:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, idx[IDX_W-1:0]};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (pts >= 8 && idx[IDX_W-1:0] < pts) begin
      valid_sent++;
    end
  endtask

  // Mostly indices aimed at one region (edges of regions often), some at the
  // end of the count, and a few over the whole index range.
  function automatic logic [63:0] pick_index();
    logic [63:0] base[8];
    logic [63:0] len[8];
    logic [63:0] off, idx;
    int          roll, r, tries;
    roll = $urandom_range(99);
    if (roll < 8 || pts < 8) begin
      return 64'($urandom) & ((64'd1 << IDX_W) - 1);
    end
    if (roll < 12) begin
      return pts - 64'($urandom_range(1));
    end
    len[0] = 8;
    len[1] = 4 * spx;
    len[2] = 4 * spy;
    len[3] = 4 * spz;
    len[4] = 2 * spx * spy;
    len[5] = 2 * spx * spz;
    len[6] = 2 * spy * spz;
    base[0] = 0;
    for (int i = 1; i < 8; i++) begin
      base[i] = base[i-1] + len[i-1];
    end
    len[7] = (pts > base[7]) ? pts - base[7] : 64'd0;
    r = $urandom_range(7);
    tries = 0;
    while (len[r] == 0 && tries < 16) begin
      r = $urandom_range(7);
      tries++;
    end
    if (len[r] == 0) begin
      return 64'($urandom) % pts;
    end
    if (roll < 30) begin
      case ($urandom_range(3))
        0: off = 0;
        1: off = 1;
        2: off = len[r] - 1;
        default: off = len[r] - 2;
      endcase
      if (off >= len[r]) begin
        off = 0;
      end
    end else begin
      off = 64'($urandom) % len[r];
    end
    idx = base[r] + off;
    if (idx >= pts) begin
      idx = 64'($urandom) % pts;
    end
    return idx;
  endfunction

  task automatic run_phase(input int mode);
    set_idling(mode);
    valid_sent = 0;
    while (valid_sent < PHASE_ITEMS) begin
      send_index(pick_index());
    end
    in_tvalid <= 1'b0;
    set_idling(0);
  endtask

  initial begin
    logic [63:0] seq[$];
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    valid_sent    = 0;
    pts = 0;
    spx = 0;
    spy = 0;
    spz = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Registers still at reset: too few points, nothing comes out.
    send_index(0);
    send_index(64'h7FFFFF);
    in_tvalid <= 1'b0;

    // Small consistent cube: 2 x 3 x 1 splits, 54 points. First and last of
    // every region, then the count itself and indices past it.
    load_cube(2, 3, 1);
    seq = '{0, 5, 7, 8, 15, 16, 27, 28, 31, 32, 43, 44, 47, 48, 53, 54, 64'h7FFFFF, 64'h2AAAAA};
    foreach (seq[i]) begin
      send_index(seq[i]);
    end
    in_tvalid <= 1'b0;

    // A count of zero and one just below the vertex count.
    load_mesh(0, 0, 0, 0, 0, 0, 0);
    send_index(0);
    load_mesh(7, 1, 1, 1, 65536, 65536, 65536);
    send_index(0);
    send_index(6);
    in_tvalid <= 1'b0;

    // Largest splits, consistent.
    load_cube(1023, 1023, 1023);
    run_phase(0);
    // Largest count with largest spacing: indices run past every region and
    // the coordinates clamp at +1.
    load_mesh(64'h800000, 1023, 1023, 1023, 131072, 131072, 131072);
    run_phase(1);
    // No z splits: the faces that divide by split_z get a zero divisor.
    load_mesh(64'h800000, $urandom_range(1, 40), $urandom_range(1, 40), 0,
              $urandom_range(131072), $urandom_range(131072), $urandom_range(131072));
    run_phase(2);
    load_cube(0, 0, 0);
    run_phase(3);
    load_cube($urandom_range(1, 30), $urandom_range(1, 30), $urandom_range(1, 30));
    run_phase(0);
    load_mesh($urandom_range(8, 64'h800000), $urandom_range(1023), $urandom_range(1023),
              $urandom_range(1023), $urandom_range(131072), $urandom_range(131072),
              $urandom_range(131072));
    run_phase(1);
    load_cube($urandom_range(1023), $urandom_range(1023), $urandom_range(1023));
    run_phase(2);
    load_cube($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 6));
    run_phase(3);

    wait_idle();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
